FILE: design/qxmix_pkg.sv
// shared constants and types for the quad x motor mixer
package qxmix_pkg;

	localparam int MOTOR_COUNT = 4;
	localparam int VAL_W       = 32;
	localparam int PW_W        = 16;
	localparam int GAIN_W      = 16;
	localparam int SUPPLY_W    = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int PROD_W      = GAIN_W + VAL_W + 1;
	localparam int VOLT_W      = PROD_W + 2;
	localparam int MAG_W       = VOLT_W - 1;
	localparam int DIV_STEPS   = 4;

	localparam logic [GAIN_W-1:0] THRUST_GAIN_RST = 16'd646;
	localparam logic [GAIN_W-1:0] TILT_GAIN_RST   = 16'd3383;
	localparam logic [GAIN_W-1:0] YAW_GAIN_RST    = 16'd12916;
	localparam logic [PW_W-1:0]   PWM_MIN_RST     = 16'd1000;
	localparam logic [PW_W-1:0]   PWM_MAX_RST     = 16'd2000;

	typedef enum logic [1:0] {
		ACT_WRENCH   = 2'd0,
		ACT_VOLTS    = 2'd1,
		ACT_FRACTION = 2'd2,
		ACT_RAW      = 2'd3
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRUST_GAIN = 3'd0,
		REG_TILT_GAIN   = 3'd1,
		REG_YAW_GAIN    = 3'd2,
		REG_PWM_MIN     = 3'd3,
		REG_PWM_MAX     = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic                                is_raw;
		logic [MOTOR_COUNT-1:0]              sign;
		logic [MOTOR_COUNT-1:0]              raw_clip;
		logic [MOTOR_COUNT-1:0][PW_W-1:0]    raw_w;
	} side_t;

endpackage

FILE: design/qxmix_div.sv
// pipelined restoring divider lane, DIV_STEPS (four) quotient bits per stage
module qxmix_div #(
	parameter int QBITS = 18
) (
	input  logic                              clk,
	input  logic                              adv,
	input  logic [qxmix_pkg::SUPPLY_W-1:0]    rem_init,
	input  logic [QBITS-1:0]                  bits,
	input  logic [qxmix_pkg::SUPPLY_W-1:0]    divisor,
	input  logic                              ovf,
	output logic [QBITS-1:0]                  quot
);
	import qxmix_pkg::*;

	localparam int NST = (QBITS + DIV_STEPS - 1) / DIV_STEPS;

	logic [SUPPLY_W-1:0] rem_s [NST];
	logic [QBITS-1:0]    sh_s  [NST];
	logic [SUPPLY_W-1:0] dvs_s [NST];
	logic                ovf_s [NST];

	genvar k;
	for (k = 0; k < NST; k++) begin : g_stage
		logic [SUPPLY_W-1:0] rem_p;
		logic [SUPPLY_W-1:0] rem_c;
		logic [SUPPLY_W-1:0] dvs_p;
		logic [QBITS-1:0]    sh_p;
		logic [QBITS-1:0]    sh_c;
		logic                ovf_p;
		logic [SUPPLY_W:0]   trial;

		if (k == 0) begin : g_first
			assign rem_p = rem_init;
			assign sh_p  = bits;
			assign dvs_p = divisor;
			assign ovf_p = ovf;
		end else begin : g_next
			assign rem_p = rem_s[k-1];
			assign sh_p  = sh_s[k-1];
			assign dvs_p = dvs_s[k-1];
			assign ovf_p = ovf_s[k-1];
		end

		always_comb begin
			rem_c = rem_p;
			sh_c  = sh_p;
			trial = '0;
			for (int j = 0; j < DIV_STEPS; j++) begin
				if (k * DIV_STEPS + j < QBITS) begin
					trial = {rem_c, sh_c[QBITS-1]};
					if (trial >= {1'b0, dvs_p}) begin
						rem_c = SUPPLY_W'(trial - {1'b0, dvs_p});
						sh_c  = {sh_c[QBITS-2:0], 1'b1};
					end else begin
						rem_c = trial[SUPPLY_W-1:0];
						sh_c  = {sh_c[QBITS-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k] <= rem_c;
				sh_s[k]  <= sh_c;
				dvs_s[k] <= dvs_p;
				ovf_s[k] <= ovf_p;
			end
		end
	end

	// fractions beyond two are pinned to two
	assign quot = ovf_s[NST-1] ? {1'b1, {(QBITS-1){1'b0}}} : sh_s[NST-1];

endmodule

FILE: design/quad_x_motor_mixer_pwm.sv
// quad x motor mixer: wrench or motor values to saturated pulse widths
//
// channel  dir  handshake                    beat
// item     in   item_valid / item_ready      action, value_0..3, supply_voltage
// result   out  result_valid / result_ready  pulse_width_0..3, clipped
// config   in   cfg_write                    cfg_index, cfg_data
//
// one item accepted per cycle while no result is held; the pipeline depth is set
// by the four divider lanes, whose stages retire four quotient bits each.
// reset clears the valid bits and loads the register defaults.
// a result not taken holds every stage; item_ready falls with it.
module quad_x_motor_mixer_pwm #(
	parameter int FRACTION_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  logic [1:0]                          action,
	input  logic signed [qxmix_pkg::VAL_W-1:0]  value_0,
	input  logic signed [qxmix_pkg::VAL_W-1:0]  value_1,
	input  logic signed [qxmix_pkg::VAL_W-1:0]  value_2,
	input  logic signed [qxmix_pkg::VAL_W-1:0]  value_3,
	input  logic [qxmix_pkg::SUPPLY_W-1:0]      supply_voltage,
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic [qxmix_pkg::PW_W-1:0]          pulse_width_0,
	output logic [qxmix_pkg::PW_W-1:0]          pulse_width_1,
	output logic [qxmix_pkg::PW_W-1:0]          pulse_width_2,
	output logic [qxmix_pkg::PW_W-1:0]          pulse_width_3,
	output logic                                clipped,
	input  logic                                cfg_write,
	input  logic [qxmix_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [qxmix_pkg::GAIN_W-1:0]        cfg_data
);
	import qxmix_pkg::*;

	localparam int QB         = FRACTION_BITS + 2;
	localparam int DIV_STAGES = (QB + DIV_STEPS - 1) / DIV_STEPS;
	localparam int LAT        = 8 + DIV_STAGES;
	localparam int LIM_W      = SUPPLY_W + FRACTION_BITS + 2;
	localparam int PRD_W      = QB + PW_W;
	localparam int OFF_W      = PRD_W - FRACTION_BITS;

	// configuration
	logic [GAIN_W-1:0] thrust_gain_q;
	logic [GAIN_W-1:0] tilt_gain_q;
	logic [GAIN_W-1:0] yaw_gain_q;
	logic [PW_W-1:0]   pwm_min_q;
	logic [PW_W-1:0]   pwm_max_q;
	logic [PW_W-1:0]   lo;
	logic [PW_W-1:0]   hi;
	logic [PW_W-1:0]   span;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thrust_gain_q <= THRUST_GAIN_RST;
			tilt_gain_q   <= TILT_GAIN_RST;
			yaw_gain_q    <= YAW_GAIN_RST;
			pwm_min_q     <= PWM_MIN_RST;
			pwm_max_q     <= PWM_MAX_RST;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_THRUST_GAIN: thrust_gain_q <= cfg_data;
				REG_TILT_GAIN:   tilt_gain_q   <= cfg_data;
				REG_YAW_GAIN:    yaw_gain_q    <= cfg_data;
				REG_PWM_MIN:     pwm_min_q     <= cfg_data;
				REG_PWM_MAX:     pwm_max_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign lo   = pwm_min_q;
	assign hi   = (pwm_max_q < pwm_min_q) ? pwm_min_q : pwm_max_q;
	assign span = hi - lo;

	// flow control
	logic [LAT-1:0] valid_s;
	logic           adv;

	assign adv          = !valid_s[LAT-1] || result_ready;
	assign item_ready   = adv;
	assign result_valid = valid_s[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (adv) begin
			valid_s <= {valid_s[LAT-2:0], item_valid};
		end
	end

	// stage 1: capture
	logic signed [VAL_W-1:0] val_in [MOTOR_COUNT];
	logic [SUPPLY_W-1:0]     div_in;
	action_t                 action_s1;
	logic signed [VAL_W-1:0] val_s1 [MOTOR_COUNT];
	logic [SUPPLY_W-1:0]     div_s1;

	assign val_in[0] = value_0;
	assign val_in[1] = value_1;
	assign val_in[2] = value_2;
	assign val_in[3] = value_3;

	always_comb begin
		if (action_t'(action) == ACT_FRACTION || action_t'(action) == ACT_RAW ||
			supply_voltage == '0) begin
			div_in = SUPPLY_W'(1);
		end else begin
			div_in = supply_voltage;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			action_s1 <= action_t'(action);
			val_s1    <= val_in;
			div_s1    <= div_in;
		end
	end

	// stage 2: gain products and raw width saturation
	side_t                    side_c2;
	logic signed [PROD_W-1:0] prod_t_s2;
	logic signed [PROD_W-1:0] prod_r_s2;
	logic signed [PROD_W-1:0] prod_p_s2;
	logic signed [PROD_W-1:0] prod_y_s2;
	logic signed [VAL_W-1:0]  val_s2 [MOTOR_COUNT];
	action_t                  action_s2;
	logic [SUPPLY_W-1:0]      div_s2;
	side_t                    side_s2;

	always_comb begin
		side_c2        = '0;
		side_c2.is_raw = (action_s1 == ACT_RAW);
		for (int i = 0; i < MOTOR_COUNT; i++) begin
			if (val_s1[i][VAL_W-1] || (val_s1[i][VAL_W-2:0] < (VAL_W-1)'(lo))) begin
				side_c2.raw_w[i]    = lo;
				side_c2.raw_clip[i] = 1'b1;
			end else if (val_s1[i][VAL_W-2:0] > (VAL_W-1)'(hi)) begin
				side_c2.raw_w[i]    = hi;
				side_c2.raw_clip[i] = 1'b1;
			end else begin
				side_c2.raw_w[i]    = val_s1[i][PW_W-1:0];
				side_c2.raw_clip[i] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_t_s2 <= $signed({1'b0, thrust_gain_q}) * val_s1[0];
			prod_r_s2 <= $signed({1'b0, tilt_gain_q}) * val_s1[1];
			prod_p_s2 <= $signed({1'b0, tilt_gain_q}) * val_s1[2];
			prod_y_s2 <= $signed({1'b0, yaw_gain_q}) * val_s1[3];
			val_s2    <= val_s1;
			action_s2 <= action_s1;
			div_s2    <= div_s1;
			side_s2   <= side_c2;
		end
	end

	// stage 3: common sums
	logic signed [VOLT_W-1:0] a_s3;
	logic signed [VOLT_W-1:0] d1_s3;
	logic signed [VOLT_W-1:0] d2_s3;
	logic signed [VAL_W-1:0]  val_s3 [MOTOR_COUNT];
	action_t                  action_s3;
	logic [SUPPLY_W-1:0]      div_s3;
	side_t                    side_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s3      <= VOLT_W'(prod_t_s2) + VOLT_W'(prod_y_s2);
			d1_s3     <= VOLT_W'(prod_r_s2) + VOLT_W'(prod_p_s2);
			d2_s3     <= VOLT_W'(prod_r_s2) - VOLT_W'(prod_p_s2);
			val_s3    <= val_s2;
			action_s3 <= action_s2;
			div_s3    <= div_s2;
			side_s3   <= side_s2;
		end
	end

	// stage 4: dividend per motor
	logic signed [VOLT_W-1:0] dvd_c  [MOTOR_COUNT];
	logic signed [VOLT_W-1:0] dvd_s4 [MOTOR_COUNT];
	logic [SUPPLY_W-1:0]      div_s4;
	side_t                    side_s4;

	always_comb begin
		case (action_s3)
			ACT_WRENCH: begin
				dvd_c[0] = a_s3 - d1_s3;
				dvd_c[1] = a_s3 + d2_s3;
				dvd_c[2] = a_s3 + d1_s3;
				dvd_c[3] = a_s3 - d2_s3;
			end
			ACT_VOLTS: begin
				for (int i = 0; i < MOTOR_COUNT; i++) begin
					dvd_c[i] = VOLT_W'(val_s3[i]) <<< 8;
				end
			end
			default: begin
				for (int i = 0; i < MOTOR_COUNT; i++) begin
					dvd_c[i] = VOLT_W'(val_s3[i]);
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dvd_s4  <= dvd_c;
			div_s4  <= div_s3;
			side_s4 <= side_s3;
		end
	end

	// stage 5: magnitude and overflow bound
	logic [MAG_W-1:0]    mag_s5 [MOTOR_COUNT];
	logic [LIM_W-1:0]    lim_s5;
	logic [SUPPLY_W-1:0] div_s5;
	side_t               side_c5;
	side_t               side_s5;

	always_comb begin
		side_c5 = side_s4;
		for (int i = 0; i < MOTOR_COUNT; i++) begin
			side_c5.sign[i] = dvd_s4[i][VOLT_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < MOTOR_COUNT; i++) begin
				mag_s5[i] <= dvd_s4[i][VOLT_W-1] ? MAG_W'(-dvd_s4[i]) : MAG_W'(dvd_s4[i]);
			end
			lim_s5  <= (LIM_W'(div_s4) << (FRACTION_BITS + 1)) + LIM_W'(div_s4);
			div_s5  <= div_s4;
			side_s5 <= side_c5;
		end
	end

	// stage 6: overflow compare
	logic [MAG_W-1:0]    mag_s6 [MOTOR_COUNT];
	logic [MOTOR_COUNT-1:0] ovf_s6;
	logic [SUPPLY_W-1:0] div_s6;
	side_t               side_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < MOTOR_COUNT; i++) begin
				ovf_s6[i] <= mag_s5[i] >= MAG_W'(lim_s5);
			end
			mag_s6  <= mag_s5;
			div_s6  <= div_s5;
			side_s6 <= side_s5;
		end
	end

	// divider lanes
	logic [QB-1:0] quot [MOTOR_COUNT];
	side_t         side_sd [DIV_STAGES];

	genvar m;
	for (m = 0; m < MOTOR_COUNT; m++) begin : g_lane
		qxmix_div #(
			.QBITS(QB)
		) u_div (
			.clk     (clk),
			.adv     (adv),
			.rem_init(mag_s6[m][QB +: SUPPLY_W]),
			.bits    (mag_s6[m][QB-1:0]),
			.divisor (div_s6),
			.ovf     (ovf_s6[m]),
			.quot    (quot[m])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_sd[0] <= side_s6;
			for (int k = 1; k < DIV_STAGES; k++) begin
				side_sd[k] <= side_sd[k-1];
			end
		end
	end

	// stage 7: scale by span
	logic [PRD_W-1:0] prod_s7 [MOTOR_COUNT];
	side_t            side_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < MOTOR_COUNT; i++) begin
				prod_s7[i] <= PRD_W'(quot[i]) * PRD_W'(span);
			end
			side_s7 <= side_sd[DIV_STAGES-1];
		end
	end

	// stage 8: offset, saturation, output register
	logic [OFF_W-1:0]       off_c  [MOTOR_COUNT];
	logic [PW_W-1:0]        pw_c   [MOTOR_COUNT];
	logic [MOTOR_COUNT-1:0] clip_c;
	logic [PW_W-1:0]        pw_s8  [MOTOR_COUNT];
	logic                   clip_s8;

	always_comb begin
		for (int i = 0; i < MOTOR_COUNT; i++) begin
			off_c[i] = prod_s7[i][PRD_W-1:FRACTION_BITS];
			if (side_s7.is_raw) begin
				pw_c[i]   = side_s7.raw_w[i];
				clip_c[i] = side_s7.raw_clip[i];
			end else if (side_s7.sign[i]) begin
				pw_c[i]   = lo;
				clip_c[i] = (off_c[i] != '0);
			end else if (off_c[i] > OFF_W'(span)) begin
				pw_c[i]   = hi;
				clip_c[i] = 1'b1;
			end else begin
				pw_c[i]   = lo + off_c[i][PW_W-1:0];
				clip_c[i] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pw_s8   <= pw_c;
			clip_s8 <= |clip_c;
		end
	end

	assign pulse_width_0 = pw_s8[0];
	assign pulse_width_1 = pw_s8[1];
	assign pulse_width_2 = pw_s8[2];
	assign pulse_width_3 = pw_s8[3];
	assign clipped       = clip_s8;

endmodule

FILE: sim/qxmix_pwm_checker.sv
`timescale 1ns / 1ps
// checker for the quad x motor mixer: predicts pulse widths per item beat and compares result beats
module qxmix_pwm_checker #(
	parameter int FRACTION_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	input  logic                                item_ready,
	input  logic [1:0]                          action,
	input  logic signed [qxmix_pkg::VAL_W-1:0]  value_0,
	input  logic signed [qxmix_pkg::VAL_W-1:0]  value_1,
	input  logic signed [qxmix_pkg::VAL_W-1:0]  value_2,
	input  logic signed [qxmix_pkg::VAL_W-1:0]  value_3,
	input  logic [qxmix_pkg::SUPPLY_W-1:0]      supply_voltage,
	input  logic                                result_valid,
	input  logic                                result_ready,
	input  logic [qxmix_pkg::PW_W-1:0]          pulse_width_0,
	input  logic [qxmix_pkg::PW_W-1:0]          pulse_width_1,
	input  logic [qxmix_pkg::PW_W-1:0]          pulse_width_2,
	input  logic [qxmix_pkg::PW_W-1:0]          pulse_width_3,
	input  logic                                clipped,
	input  logic                                cfg_write,
	input  logic [qxmix_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [qxmix_pkg::GAIN_W-1:0]        cfg_data,
	output int                                  mismatches,
	output int                                  outstanding
);
	import qxmix_pkg::*;

	typedef struct packed {
		logic [MOTOR_COUNT-1:0][PW_W-1:0] width;
		logic                             clip;
	} pwm_beat_t;

	longint thrust_q;
	longint tilt_q;
	longint yaw_q;
	longint min_q;
	longint max_q;

	pwm_beat_t expected_beats[$];

	initial mismatches = 0;

	function automatic pwm_beat_t predict_widths(action_t act,
			logic [MOTOR_COUNT-1:0][VAL_W-1:0] vals, logic [SUPPLY_W-1:0] supply);
		pwm_beat_t beat;
		logic signed [VAL_W-1:0] s;
		longint one, sup, lo, hi, span, volt, frac, w, vm;
		longint t, r, p, y;
		one = longint'(1) <<< FRACTION_BITS;
		sup = supply;
		if (sup == 0)
			sup = 1;
		lo = min_q;
		hi = (max_q < min_q) ? min_q : max_q;
		span = hi - lo;
		s = vals[0]; t = s;
		s = vals[1]; r = s;
		s = vals[2]; p = s;
		s = vals[3]; y = s;
		beat.clip = 1'b0;
		for (int m = 0; m < MOTOR_COUNT; m++) begin
			s = vals[m];
			vm = s;
			if (act == ACT_RAW) begin
				w = vm;
			end else begin
				case (act)
					ACT_WRENCH: begin
						volt = thrust_q * t + yaw_q * y
							+ ((m == 0 || m == 3) ? -(tilt_q * r) : tilt_q * r)
							+ ((m < 2) ? -(tilt_q * p) : tilt_q * p);
						frac = volt / sup;
					end
					ACT_VOLTS: frac = (vm * 256) / sup;
					default: frac = vm;
				endcase
				if (frac > 2 * one)
					frac = 2 * one;
				if (frac < -2 * one)
					frac = -2 * one;
				w = lo + (frac * span) / one;
			end
			if (w < lo) begin
				w = lo;
				beat.clip = 1'b1;
			end else if (w > hi) begin
				w = hi;
				beat.clip = 1'b1;
			end
			beat.width[m] = w[PW_W-1:0];
		end
		return beat;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		pwm_beat_t want;
		logic [MOTOR_COUNT-1:0][PW_W-1:0] seen;
		if (!arst_n) begin
			thrust_q = THRUST_GAIN_RST;
			tilt_q = TILT_GAIN_RST;
			yaw_q = YAW_GAIN_RST;
			min_q = PWM_MIN_RST;
			max_q = PWM_MAX_RST;
			expected_beats.delete();
			outstanding <= 0;
		end else begin
			if (result_valid && result_ready) begin
				if (expected_beats.size() == 0) begin
					$error("result beat with no expected widths pending");
					mismatches++;
				end else begin
					want = expected_beats.pop_front();
					seen = {pulse_width_3, pulse_width_2, pulse_width_1, pulse_width_0};
					for (int m = 0; m < MOTOR_COUNT; m++) begin
						if (seen[m] !== want.width[m]) begin
							$error("pulse_width_%0d: expected %0d, actual %0d",
								m, want.width[m], seen[m]);
							mismatches++;
						end
					end
					if (clipped !== want.clip) begin
						$error("clipped: expected %0d, actual %0d", want.clip, clipped);
						mismatches++;
					end
				end
			end
			if (item_valid && item_ready)
				expected_beats.push_back(predict_widths(action_t'(action),
					{value_3, value_2, value_1, value_0}, supply_voltage));
			if (cfg_write) begin
				case (cfg_index)
					REG_THRUST_GAIN: thrust_q = cfg_data;
					REG_TILT_GAIN: tilt_q = cfg_data;
					REG_YAW_GAIN: yaw_q = cfg_data;
					REG_PWM_MIN: min_q = cfg_data;
					REG_PWM_MAX: max_q = cfg_data;
					default: ;
				endcase
			end
			outstanding <= expected_beats.size();
		end
	end

endmodule

FILE: sim/quad_x_motor_mixer_pwm_tb.sv
`timescale 1ns / 1ps
// testbench top for the quad x motor mixer: drives items, config and result stalls
module quad_x_motor_mixer_pwm_tb;
	import qxmix_pkg::*;

	localparam int FRACTION_BITS = 16;
	localparam int ONE = 1 << FRACTION_BITS;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic [1:0] action = ACT_WRENCH;
	logic signed [VAL_W-1:0] value_0 = '0;
	logic signed [VAL_W-1:0] value_1 = '0;
	logic signed [VAL_W-1:0] value_2 = '0;
	logic signed [VAL_W-1:0] value_3 = '0;
	logic [SUPPLY_W-1:0] supply_voltage = '0;
	logic result_ready = 1'b0;
	logic cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_THRUST_GAIN;
	logic [GAIN_W-1:0] cfg_data = '0;

	logic item_ready;
	logic result_valid;
	logic [PW_W-1:0] pulse_width_0;
	logic [PW_W-1:0] pulse_width_1;
	logic [PW_W-1:0] pulse_width_2;
	logic [PW_W-1:0] pulse_width_3;
	logic clipped;
	int mismatches;
	int outstanding;

	bit feed_busy = 1'b1;
	bit drain_busy = 1'b1;
	longint lo_now = PWM_MIN_RST;
	longint hi_now = PWM_MAX_RST;

	quad_x_motor_mixer_pwm #(.FRACTION_BITS(FRACTION_BITS)) uut (.*);

	qxmix_pwm_checker #(.FRACTION_BITS(FRACTION_BITS)) checker_i (.*);

	always #5 clk = ~clk;

	initial begin
		#5ms;
		$display("Test completed with failures");
		$finish;
	end

	function automatic int draw_gap(bit busy);
		return busy ? $urandom_range(0, 15) : 0;
	endfunction

	task automatic push_item(action_t a, logic [31:0] v0, logic [31:0] v1,
			logic [31:0] v2, logic [31:0] v3, logic [15:0] sup);
		int gap;
		gap = draw_gap(feed_busy);
		if ($urandom_range(0, 39) == 0)
			feed_busy = !feed_busy;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		action <= a;
		value_0 <= v0;
		value_1 <= v1;
		value_2 <= v2;
		value_3 <= v3;
		supply_voltage <= sup;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
	endtask

	task automatic wait_all_widths();
		item_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic put_reg(cfg_reg_t r, logic [15:0] d);
		cfg_write <= 1'b1;
		cfg_index <= r;
		cfg_data <= d;
		@(posedge clk);
	endtask

	task automatic load_config(logic [15:0] tg, logic [15:0] ti, logic [15:0] yg,
			logic [15:0] mn, logic [15:0] mx);
		wait_all_widths();
		put_reg(REG_THRUST_GAIN, tg);
		put_reg(REG_TILT_GAIN, ti);
		put_reg(REG_YAW_GAIN, yg);
		put_reg(REG_PWM_MIN, mn);
		put_reg(REG_PWM_MAX, mx);
		cfg_write <= 1'b0;
		lo_now = mn;
		hi_now = (mx < mn) ? mn : mx;
	endtask

	function automatic logic [31:0] pick_value(action_t a, logic [15:0] sup);
		longint f;
		int k;
		case ($urandom_range(0, 5))
			0: f = $urandom;
			1: begin
				k = $urandom_range(1, 31);
				f = $urandom & ((longint'(1) << k) - 1);
				if ($urandom_range(0, 1))
					f = -f;
			end
			default: begin
				case (a)
					ACT_WRENCH: f = ((longint'($urandom_range(0, 1 << 14)) - (1 << 12)) * sup)
						>>> $urandom_range(2, 12);
					ACT_VOLTS: f = ((longint'($urandom_range(0, ONE + ONE / 4)) - ONE / 8)
						* sup) >>> 8;
					ACT_FRACTION: f = longint'($urandom_range(0, ONE + ONE / 4)) - ONE / 8;
					default: f = lo_now - 64 + longint'($urandom_range(0, hi_now - lo_now + 128));
				endcase
			end
		endcase
		return f[31:0];
	endfunction

	task automatic run_random(int n);
		action_t a;
		logic [15:0] sup;
		for (int i = 0; i < n; i++) begin
			a = action_t'($urandom_range(0, 3));
			sup = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
				: 16'($urandom_range(256 * 6, 256 * 26));
			push_item(a, pick_value(a, sup), pick_value(a, sup), pick_value(a, sup),
				pick_value(a, sup), sup);
		end
	endtask

	// result side stalls independently of the item side
	initial begin
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = draw_gap(drain_busy);
			if ($urandom_range(0, 39) == 0)
				drain_busy = !drain_busy;
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			@(posedge clk);
			while (!result_valid) @(posedge clk);
		end
	end

	initial begin
		logic [15:0] mn;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: every action, zero supply, clamped and negative drive
		push_item(ACT_WRENCH, 0, 0, 0, 0, 16'd3072);
		push_item(ACT_WRENCH, 4 * ONE, 0, 0, 0, 16'd3072);
		push_item(ACT_WRENCH, 2 * ONE, ONE / 16, -ONE / 16, ONE / 64, 16'd3072);
		push_item(ACT_WRENCH, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			16'hffff);
		push_item(ACT_WRENCH, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
			16'd1);
		push_item(ACT_WRENCH, ONE, 0, 0, 0, 16'd0);
		push_item(ACT_VOLTS, 12 * ONE, 6 * ONE, 0, -ONE, 16'd3072);
		push_item(ACT_VOLTS, 32'h7fffffff, 32'h80000000, 0, 1, 16'd1);
		push_item(ACT_VOLTS, ONE / 256, 0, -1, ONE, 16'd0);
		push_item(ACT_FRACTION, 0, ONE / 2, ONE, ONE + 1, 16'd3072);
		push_item(ACT_FRACTION, -1, 2 * ONE + 5, 32'h7fffffff, 32'h80000000, 16'hffff);
		push_item(ACT_RAW, 1000, 2000, 999, 2001, 16'd3072);
		push_item(ACT_RAW, -1, 0, 65535, 65536, 16'd0);
		push_item(ACT_RAW, 32'h7fffffff, 32'h80000000, 1500, 1234, 16'hffff);

		// widest range and largest gains
		load_config(16'hffff, 16'hffff, 16'hffff, 16'd0, 16'hffff);
		push_item(ACT_WRENCH, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
			16'd1);
		push_item(ACT_FRACTION, ONE, ONE - 1, 1, 0, 16'd256);
		run_random(100);

		// zero gains, zero span
		load_config(16'd0, 16'd0, 16'd0, 16'd1500, 16'd1500);
		run_random(60);

		// inverted range
		load_config(16'd646, 16'd3383, 16'd12916, 16'd2000, 16'd1000);
		run_random(60);

		load_config(16'd1, 16'd1, 16'd1, 16'd0, 16'd0);
		run_random(40);

		for (int ph = 0; ph < 3; ph++) begin
			mn = 16'($urandom_range(0, 60000));
			load_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
				16'($urandom_range(0, 65535)), mn,
				16'(mn + $urandom_range(0, 65535 - mn)));
			run_random(40);
			wait_all_widths();
			run_random(40);
		end

		load_config(THRUST_GAIN_RST, TILT_GAIN_RST, YAW_GAIN_RST, PWM_MIN_RST,
			PWM_MAX_RST);
		run_random(60);

		wait_all_widths();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
